### hdl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU response receiver package
// Item types, kind and status codes, and the CRC-16/Modbus byte fold.
// ----------------------------------------------------------------------------
package mrr_pkg;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_RESP   = 2'd1;
    localparam logic [1:0] ST_EXCEPTION = 2'd2;
    localparam logic [1:0] ST_CRC_ERR   = 2'd3;

    localparam logic OUT_WORD   = 1'b0;
    localparam logic OUT_STATUS = 1'b1;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
    localparam logic [6:0]  MAX_REGS     = 7'd125;
    localparam logic [7:0]  HDR_BYTES    = 8'd5;
    localparam logic [4:0]  SILENCE_MAX  = 5'd31;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] expected_regs;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        out_kind;
        logic [15:0] reg_value;
        logic [6:0]  reg_index;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    // Handshake between the output stage and the frame logic
    typedef struct packed {
        logic go;       // frame logic consumes the held item this cycle
        logic res_vld;  // the consumed item yields a result
    } t_step_ctl;

    function automatic logic [15:0] crc16_fold(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### hdl/mrr_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted item until the frame logic consumes it.
// ----------------------------------------------------------------------------
module mrr_in_reg
    import mrr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_item;
        end
    end

endmodule

### hdl/mrr_frame.sv
// ----------------------------------------------------------------------------
// Frame tracker
// Applies one item to the frame state: byte count, lagging CRC, word
// assembly, millisecond timers and the end-of-frame status.
// ----------------------------------------------------------------------------
module mrr_frame
    import mrr_pkg::*;
#(
    parameter int FRAME_BYTES = 256,
    parameter int GAP_MS      = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_go,
    input  t_in_item    i_item,
    output t_step_ctl   o_ctl,
    output t_out_item   o_res
);

    localparam int CW   = $clog2(FRAME_BYTES + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;

    logic [15:0]   r_timeout;
    logic          r_waiting;
    logic [CW-1:0] r_count;
    logic [15:0]   r_crc;
    logic [15:0]   r_held;
    logic          r_exc;
    logic [7:0]    r_plen;
    logic [7:0]    r_hi;
    logic [7:0]    r_exp;
    logic [15:0]   r_elapsed;
    logic [4:0]    r_silence;

    logic          n_waiting;
    logic [CW-1:0] n_count;
    logic [15:0]   n_crc;
    logic [15:0]   n_held;
    logic          n_exc;
    logic [7:0]    n_plen;
    logic [7:0]    n_hi;
    logic [7:0]    n_exp;
    logic [15:0]   n_elapsed;
    logic [4:0]    n_silence;

    logic            res_vld;
    t_out_item       res;
    logic [CMPW-1:0] cnt_ext;
    logic [6:0]      regs_sat;
    logic [1:0]      end_status;

    assign cnt_ext  = CMPW'(r_count);
    assign regs_sat = (i_item.expected_regs > MAX_REGS) ? MAX_REGS : i_item.expected_regs;

    always_comb begin
        if (r_count == '0) begin
            end_status = ST_NO_RESP;
        end else if (r_exc) begin
            end_status = ST_EXCEPTION;
        end else if (r_count == CW'(1)) begin
            end_status = ST_CRC_ERR;
        end else if ({r_held[7:0], r_held[15:8]} == r_crc) begin
            end_status = ST_OK;
        end else begin
            end_status = ST_CRC_ERR;
        end
    end

    always_comb begin
        n_waiting = r_waiting;
        n_count   = r_count;
        n_crc     = r_crc;
        n_held    = r_held;
        n_exc     = r_exc;
        n_plen    = r_plen;
        n_hi      = r_hi;
        n_exp     = r_exp;
        n_elapsed = r_elapsed;
        n_silence = r_silence;
        res_vld   = 1'b0;
        res       = '0;

        case (i_item.kind)
            KIND_START: begin
                n_waiting = 1'b1;
                n_count   = '0;
                n_crc     = CRC_INIT;
                n_held    = '0;
                n_exc     = 1'b0;
                n_plen    = '0;
                n_hi      = '0;
                n_exp     = HDR_BYTES + {regs_sat, 1'b0};
                n_elapsed = '0;
                n_silence = '0;
            end
            KIND_BYTE: begin
                // drop bytes while idle or beyond the frame buffer
                if (r_waiting && r_count < CW'(FRAME_BYTES)) begin
                    if (cnt_ext >= CMPW'(2)) begin
                        n_crc = crc16_fold(r_crc, r_held[15:8]);
                    end
                    n_held = {r_held[7:0], i_item.rx_byte};
                    if (r_count == CW'(1)) begin
                        n_exc = i_item.rx_byte[7];
                    end
                    if (r_count == CW'(2)) begin
                        n_plen = i_item.rx_byte;
                    end
                    if (cnt_ext >= CMPW'(3) && r_count[0]) begin
                        n_hi = i_item.rx_byte;
                    end
                    if (cnt_ext >= CMPW'(4) && !r_count[0]
                        && (cnt_ext - CMPW'(4)) < CMPW'(r_plen)
                        && (cnt_ext + CMPW'(1)) < CMPW'(r_exp)) begin
                        res_vld       = 1'b1;
                        res.out_kind  = OUT_WORD;
                        res.reg_value = {r_hi, i_item.rx_byte};
                        res.reg_index = 7'((cnt_ext - CMPW'(4)) >> 1);
                    end
                    n_count   = r_count + CW'(1);
                    n_silence = '0;
                end
            end
            KIND_TICK: begin
                if (r_waiting) begin
                    if (r_elapsed != 16'hFFFF) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                    if (r_silence != SILENCE_MAX) begin
                        n_silence = r_silence + 5'd1;
                    end
                    if ((cnt_ext >= CMPW'(r_exp) && n_silence > 5'(GAP_MS))
                        || n_elapsed >= r_timeout) begin
                        res_vld    = 1'b1;
                        res.out_kind = OUT_STATUS;
                        res.status = end_status;
                        res.last   = 1'b1;
                        n_waiting  = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ctl.go      = i_go;
    assign o_ctl.res_vld = i_go && res_vld;
    assign o_res         = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= 1'b0;
            r_count   <= '0;
            r_crc     <= CRC_INIT;
            r_held    <= '0;
            r_exc     <= 1'b0;
            r_plen    <= '0;
            r_hi      <= '0;
            r_exp     <= HDR_BYTES;
            r_elapsed <= '0;
            r_silence <= '0;
        end else if (i_go) begin
            r_waiting <= n_waiting;
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_held    <= n_held;
            r_exc     <= n_exc;
            r_plen    <= n_plen;
            r_hi      <= n_hi;
            r_exp     <= n_exp;
            r_elapsed <= n_elapsed;
            r_silence <= n_silence;
        end
    end

endmodule

### hdl/mrr_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module mrr_out_reg
    import mrr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_step_ctl i_ctl,
    input  t_out_item i_res,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_valid;
    t_out_item r_item;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.res_vld) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_vld) begin
            r_item <= i_res;
        end
    end

endmodule

### hdl/modbus_rtu_response_receiver_core.sv
// ----------------------------------------------------------------------------
// Modbus RTU read-registers response receiver
// Input channel (i_in_valid/o_in_ready) carries start, byte and 1 ms tick
// items; output channel (o_out_valid/i_out_ready) carries register words
// and one final status item per frame. Status 0 ok, 1 no reply, 2
// exception reply, 3 CRC or length error; drop the words of a frame whose
// status is not ok. i_cfg_we writes the response timeout in ms; write it
// only while no item is in flight.
// An accepted item waits in the input register until the result register
// is free; the frame logic then writes any result into that register.
// Throughput: one item per cycle while the result register is free; the
// bytewise CRC fold and the word and status logic sit in the single
// stage between the two registers. Reset (synchronous, active low) empties
// both registers, ends any frame and sets the timeout to 1000 ms. With a
// result pending and the consumer stalled, the input register takes at
// most one more item, then o_in_ready stays low until the result is taken.
// ----------------------------------------------------------------------------
module modbus_rtu_response_receiver_core
    import mrr_pkg::*;
#(
    parameter int FRAME_BYTES = 256,
    parameter int GAP_MS      = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    logic      held_vld;
    t_in_item  held_item;
    logic      out_free;
    logic      go;
    t_step_ctl ctl;
    t_out_item res;

    // advance the held item only when the result register can take its result
    assign go = held_vld && out_free;

    mrr_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_take     (go),
        .o_valid    (held_vld),
        .o_item     (held_item)
    );

    mrr_frame #(
        .FRAME_BYTES (FRAME_BYTES),
        .GAP_MS      (GAP_MS)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_go        (go),
        .i_item      (held_item),
        .o_ctl       (ctl),
        .o_res       (res)
    );

    mrr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
